// ----- hdl/single_axis_attitude_hold_assert.svh -----
// assertion macros shared by the attitude hold checker
`ifndef SINGLE_AXIS_ATTITUDE_HOLD_ASSERT_SVH
`define SINGLE_AXIS_ATTITUDE_HOLD_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SAAH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SAAH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/saah_pkg.sv -----
// shared types, constants and tables of the attitude hold block
package saah_pkg;

    localparam int ANGLE_WIDTH_DEF = 32;
    localparam int LEVEL_WIDTH_DEF = 16;

    localparam int GAIN_WIDTH    = 32;
    localparam int DB_WIDTH      = 31;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int AXIS_WIDTH    = 2;
    localparam int BAND_WIDTH    = 3;
    localparam int CONST_WIDTH   = 22;
    // product bit at which gain * error reaches full scale
    localparam int PROD_TOP      = 40;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ANGLE_DEADBAND = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_X         = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_Y         = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_GAIN_Z         = 2'd3;

    // axis codes
    localparam logic [AXIS_WIDTH-1:0] AXIS_PITCH = 2'd0;
    localparam logic [AXIS_WIDTH-1:0] AXIS_YAW   = 2'd1;
    localparam logic [AXIS_WIDTH-1:0] AXIS_ROLL  = 2'd2;

    // band codes
    localparam logic [BAND_WIDTH-1:0] BAND_HOLD = 3'd0;
    localparam logic [BAND_WIDTH-1:0] BAND_FINE = 3'd1;
    localparam logic [BAND_WIDTH-1:0] BAND_LOW  = 3'd2;
    localparam logic [BAND_WIDTH-1:0] BAND_MID  = 3'd3;
    localparam logic [BAND_WIDTH-1:0] BAND_HIGH = 3'd4;
    localparam logic [BAND_WIDTH-1:0] BAND_MAX  = 3'd5;

    // reset values
    localparam logic [DB_WIDTH-1:0]   DEADBAND_RST = 31'd2928;
    localparam logic [GAIN_WIDTH-1:0] GAIN_RST     = 32'd65536;

    // 0.0001 deg/s in q7.24
    localparam logic [CONST_WIDTH-1:0] RATE_NULL_Q = 22'd29;

    // error band edges: 0.15, 1, 3, 10 deg
    localparam logic [CONST_WIDTH-1:0] BAND_EDGE_0 = 22'd43923;
    localparam logic [CONST_WIDTH-1:0] BAND_EDGE_1 = 22'd292818;
    localparam logic [CONST_WIDTH-1:0] BAND_EDGE_2 = 22'd878453;
    localparam logic [CONST_WIDTH-1:0] BAND_EDGE_3 = 22'd2928177;

    typedef struct packed {
        logic [DB_WIDTH-1:0]   angle_deadband;
        logic [GAIN_WIDTH-1:0] gain_x;
        logic [GAIN_WIDTH-1:0] gain_y;
        logic [GAIN_WIDTH-1:0] gain_z;
    } t_cfg;

    typedef struct packed {
        logic                  drive;
        logic                  neg;
        logic                  done;
        logic [BAND_WIDTH-1:0] band;
    } t_law;

    // commanded rate per band: 0.01, 0.25, 0.5, 1, 2 deg/s
    function automatic logic [CONST_WIDTH-1:0] band_rate(input logic [BAND_WIDTH-1:0] b);
        logic [CONST_WIDTH-1:0] r;
        case (b)
            BAND_FINE: r = 22'd2928;
            BAND_LOW:  r = 22'd73204;
            BAND_MID:  r = 22'd146409;
            BAND_HIGH: r = 22'd292818;
            BAND_MAX:  r = 22'd585635;
            default:   r = '0;
        endcase
        return r;
    endfunction

    // rate deadband per band: half the rate, capped at 0.01 deg/s
    function automatic logic [CONST_WIDTH-1:0] band_rdb(input logic [BAND_WIDTH-1:0] b);
        logic [CONST_WIDTH-1:0] r;
        case (b)
            BAND_FINE: r = 22'd1464;
            default:   r = 22'd2928;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/single_axis_attitude_hold.sv -----
// single-axis attitude hold: throughput one transaction per cycle while the
// result side does not stall; input register, one pass of law and scaling
// logic (a 32 x 33 multiply at default widths), then the result register
// the result register frees as it is taken, so input keeps flowing behind it
// reset (synchronous, active low) empties both stages and loads the register
// defaults: angle deadband 2928 (0.01 deg), all gains 65536 (1.0)
module single_axis_attitude_hold #(
    parameter int ANGLE_WIDTH = saah_pkg::ANGLE_WIDTH_DEF,
    parameter int LEVEL_WIDTH = saah_pkg::LEVEL_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // input transaction
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [ANGLE_WIDTH-1:0]        i_target_angle,
    input  logic signed [ANGLE_WIDTH-1:0]        i_current_angle,
    input  logic signed [ANGLE_WIDTH-1:0]        i_rot_rate,
    input  logic [saah_pkg::AXIS_WIDTH-1:0]      i_axis,
    // result transaction
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [LEVEL_WIDTH-1:0]        o_level,
    output logic                                 o_done_res,
    output logic [saah_pkg::BAND_WIDTH-1:0]      o_band,
    // configuration write
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [saah_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [saah_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data
);

    // input stage
    logic                                r_in_valid;
    logic signed [ANGLE_WIDTH-1:0]       r_target_angle;
    logic signed [ANGLE_WIDTH-1:0]       r_current_angle;
    logic signed [ANGLE_WIDTH-1:0]       r_rot_rate;
    logic [saah_pkg::AXIS_WIDTH-1:0]     r_axis;

    // result stage
    logic                                r_out_valid;
    logic signed [LEVEL_WIDTH-1:0]       r_level;
    logic                                r_done_res;
    logic [saah_pkg::BAND_WIDTH-1:0]     r_band;

    logic                                n_in_valid;
    logic                                n_out_valid;
    logic                                out_move;
    logic                                in_take;

    saah_pkg::t_cfg                      cfg;
    saah_pkg::t_law                      law;
    logic [ANGLE_WIDTH:0]                mag;
    logic [saah_pkg::GAIN_WIDTH-1:0]     gain;
    logic signed [LEVEL_WIDTH-1:0]       level;

    saah_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    // result stage loads whenever it is empty or being taken this cycle
    assign out_move = !r_out_valid || !i_stall;
    // input stage frees up when its item moves on to the result stage
    assign in_take  = !r_in_valid || out_move;
    assign o_stall  = !in_take;

    assign n_in_valid  = in_take ? i_valid : r_in_valid;
    assign n_out_valid = out_move ? r_in_valid : r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take && i_valid) begin
            r_target_angle  <= i_target_angle;
            r_current_angle <= i_current_angle;
            r_rot_rate      <= i_rot_rate;
            r_axis          <= i_axis;
        end
    end

    // deadband and band decision, commanded rate error, gain for the axis
    saah_law #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_law (
        .i_target_angle  (r_target_angle),
        .i_current_angle (r_current_angle),
        .i_rot_rate      (r_rot_rate),
        .i_axis          (r_axis),
        .i_cfg           (cfg),
        .o_mag           (mag),
        .o_gain          (gain),
        .o_law           (law)
    );

    // gain * magnitude truncated to q1.15 and saturated both ways
    saah_scale #(
        .ANGLE_WIDTH (ANGLE_WIDTH),
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_scale (
        .i_mag   (mag),
        .i_gain  (gain),
        .i_drive (law.drive),
        .i_neg   (law.neg),
        .o_level (level)
    );

    // result register, held while the downstream side stalls
    always_ff @(posedge i_clk) begin
        if (out_move && r_in_valid) begin
            r_level    <= level;
            r_done_res <= law.done;
            r_band     <= law.band;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_level    = r_level;
    assign o_done_res = r_done_res;
    assign o_band     = r_band;

endmodule

// ----- hdl/saah_cfg.sv -----
// configuration register bank: deadband and per-axis gains
module saah_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [saah_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_index,
    input  logic [saah_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    output logic                                 o_cfg_ready,
    output saah_pkg::t_cfg                       o_cfg
);

    saah_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.angle_deadband <= saah_pkg::DEADBAND_RST;
            r_cfg.gain_x         <= saah_pkg::GAIN_RST;
            r_cfg.gain_y         <= saah_pkg::GAIN_RST;
            r_cfg.gain_z         <= saah_pkg::GAIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                saah_pkg::REG_ANGLE_DEADBAND: begin
                    r_cfg.angle_deadband <= i_cfg_data[saah_pkg::DB_WIDTH-1:0];
                end
                saah_pkg::REG_GAIN_X: r_cfg.gain_x <= i_cfg_data;
                saah_pkg::REG_GAIN_Y: r_cfg.gain_y <= i_cfg_data;
                saah_pkg::REG_GAIN_Z: r_cfg.gain_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ----- hdl/saah_law.sv -----
// control law: deadband test, band select, rate error and gain select
module saah_law #(
    parameter int ANGLE_WIDTH = saah_pkg::ANGLE_WIDTH_DEF
) (
    input  logic signed [ANGLE_WIDTH-1:0]          i_target_angle,
    input  logic signed [ANGLE_WIDTH-1:0]          i_current_angle,
    input  logic signed [ANGLE_WIDTH-1:0]          i_rot_rate,
    input  logic [saah_pkg::AXIS_WIDTH-1:0]        i_axis,
    input  saah_pkg::t_cfg                         i_cfg,
    output logic [ANGLE_WIDTH:0]                   o_mag,
    output logic [saah_pkg::GAIN_WIDTH-1:0]        o_gain,
    output saah_pkg::t_law                         o_law
);

    localparam int EW  = ANGLE_WIDTH + 1;
    localparam int CMW = (EW > saah_pkg::DB_WIDTH) ? EW : saah_pkg::DB_WIDTH;

    logic signed [EW-1:0]   err;
    logic [EW-1:0]          aerr;
    logic signed [EW-1:0]   rate_ext;
    logic [EW-1:0]          rate_mag;
    logic signed [EW-1:0]   cmd;
    logic signed [EW-1:0]   derr;
    logic [EW-1:0]          derr_mag;
    logic [saah_pkg::BAND_WIDTH-1:0] band;
    logic                   in_db;

    // exact error, one bit wider than the angles
    assign err  = EW'(i_target_angle) - EW'(i_current_angle);
    assign aerr = err[EW-1] ? EW'(-err) : EW'(err);
    assign in_db = CMW'(aerr) < CMW'(i_cfg.angle_deadband);

    assign rate_ext = EW'(i_rot_rate);
    assign rate_mag = rate_ext[EW-1] ? EW'(-rate_ext) : EW'(rate_ext);

    // band = 1 + number of edges at or below the error
    always_comb begin
        band = saah_pkg::BAND_FINE;
        if (aerr >= EW'(saah_pkg::BAND_EDGE_0)) band = band + 3'd1;
        if (aerr >= EW'(saah_pkg::BAND_EDGE_1)) band = band + 3'd1;
        if (aerr >= EW'(saah_pkg::BAND_EDGE_2)) band = band + 3'd1;
        if (aerr >= EW'(saah_pkg::BAND_EDGE_3)) band = band + 3'd1;
    end

    // commanded rate signed like the error, zero error taken positive
    assign cmd = err[EW-1] ? -$signed(EW'(saah_pkg::band_rate(band)))
                           :  $signed(EW'(saah_pkg::band_rate(band)));
    assign derr     = cmd - rate_ext;
    assign derr_mag = derr[EW-1] ? EW'(-derr) : EW'(derr);

    always_comb begin
        case (i_axis)
            saah_pkg::AXIS_PITCH: o_gain = i_cfg.gain_x;
            saah_pkg::AXIS_YAW:   o_gain = i_cfg.gain_y;
            saah_pkg::AXIS_ROLL:  o_gain = i_cfg.gain_z;
            default:              o_gain = '0;
        endcase
    end

    always_comb begin
        if (in_db) begin
            o_mag      = rate_mag;
            o_law.band = saah_pkg::BAND_HOLD;
            o_law.neg  = ~rate_ext[EW-1];
            o_law.done = rate_mag < EW'(saah_pkg::RATE_NULL_Q);
            o_law.drive = ~o_law.done;
        end else begin
            o_mag       = derr_mag;
            o_law.band  = band;
            o_law.neg   = derr[EW-1];
            o_law.done  = 1'b0;
            o_law.drive = derr_mag > EW'(saah_pkg::band_rdb(band));
        end
    end

endmodule

// ----- hdl/saah_scale.sv -----
// level scaling: gain times error magnitude, saturate, apply sign
module saah_scale #(
    parameter int ANGLE_WIDTH = saah_pkg::ANGLE_WIDTH_DEF,
    parameter int LEVEL_WIDTH = saah_pkg::LEVEL_WIDTH_DEF
) (
    input  logic [ANGLE_WIDTH:0]                 i_mag,
    input  logic [saah_pkg::GAIN_WIDTH-1:0]      i_gain,
    input  logic                                 i_drive,
    input  logic                                 i_neg,
    output logic signed [LEVEL_WIDTH-1:0]        o_level
);

    localparam int PW = saah_pkg::GAIN_WIDTH + ANGLE_WIDTH + 1;
    localparam int LO = saah_pkg::PROD_TOP - (LEVEL_WIDTH - 1);

    logic [PW-1:0]          prod;
    logic                   sat;
    logic [LEVEL_WIDTH-2:0] lv;
    logic [LEVEL_WIDTH-1:0] lv_ext;

    assign prod   = PW'(i_gain) * PW'(i_mag);
    // at or above 2^40 the truncated level is past full scale
    assign sat    = |prod[PW-1:saah_pkg::PROD_TOP];
    assign lv     = sat ? {(LEVEL_WIDTH-1){1'b1}} : prod[saah_pkg::PROD_TOP-1:LO];
    assign lv_ext = {1'b0, lv};

    always_comb begin
        if (!i_drive) begin
            o_level = '0;
        end else if (i_neg) begin
            o_level = $signed(-lv_ext);
        end else begin
            o_level = $signed(lv_ext);
        end
    end

endmodule

// ----- hdl/saah_checker.sv -----
// port-level checker for the attitude hold block, bound to the top level
`include "single_axis_attitude_hold_assert.svh"

module saah_checker #(
    parameter int LEVEL_WIDTH = saah_pkg::LEVEL_WIDTH_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_stall,
    input logic signed [LEVEL_WIDTH-1:0]     o_level,
    input logic                              o_done_res,
    input logic [saah_pkg::BAND_WIDTH-1:0]   o_band
);

    localparam logic [LEVEL_WIDTH-1:0] LEVEL_MIN = {1'b1, {(LEVEL_WIDTH-1){1'b0}}};

    // a finished hold never drives the thruster and is reported in the hold band
    `SAAH_ASSERT_NOW(a_done_quiet, o_valid && o_done_res,
        (o_level == '0) && (o_band == saah_pkg::BAND_HOLD), "done result with drive")

    // saturation is symmetric, the most negative code never appears
    `SAAH_ASSERT_NOW(a_level_sym, o_valid, o_level != LEVEL_MIN, "level below minus full scale")

    `SAAH_ASSERT_NOW(a_band_range, o_valid, o_band <= saah_pkg::BAND_MAX, "band code out of range")

    // with the result stage empty nothing can hold back the input
    `SAAH_ASSERT_NOW(a_no_stall_empty, !o_valid, !o_stall, "input stalled with empty output")

    // a stalled result stays offered
    `SAAH_ASSERT_NEXT(a_hold_result, o_valid && i_stall, o_valid, "stalled result dropped")

endmodule

bind single_axis_attitude_hold saah_checker #(
    .LEVEL_WIDTH (LEVEL_WIDTH)
) u_saah_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_stall    (o_stall),
    .o_level    (o_level),
    .o_done_res (o_done_res),
    .o_band     (o_band)
);

// ----- tb/sv/single_axis_attitude_hold_tb.sv -----
// self-checking testbench of the single-axis attitude hold block
`timescale 1ns / 100ps

module single_axis_attitude_hold_tb;

    localparam int ANGLE_W = 32;
    localparam int LEVEL_W = 16;
    // package widths, local copies so they can size casts
    localparam int AXIS_WIDTH     = saah_pkg::AXIS_WIDTH;
    localparam int BAND_WIDTH     = saah_pkg::BAND_WIDTH;
    localparam int DB_WIDTH       = saah_pkg::DB_WIDTH;
    localparam int GAIN_WIDTH     = saah_pkg::GAIN_WIDTH;
    localparam int CFG_IDX_WIDTH  = saah_pkg::CFG_IDX_WIDTH;
    localparam int CFG_DATA_WIDTH = saah_pkg::CFG_DATA_WIDTH;
    // q.40 product down to q1.15
    localparam int PROD_SHIFT = 41 - LEVEL_W;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL = 16'h7FFF;
    // cycles with no transaction on any channel before the run is declared hung
    localparam int QUIET_LIMIT = 1000;
    // result path is two stages deep; a little slack on top
    localparam int DRAIN_CYCLES = 4;

    // commanded rate and rate deadband per error band, q7.24 rad/s
    localparam longint CMD_RATE[5] = '{2928, 73204, 146409, 292818, 585635};
    localparam longint RATE_DB[5]  = '{1464, 2928, 2928, 2928, 2928};
    localparam longint ERR_EDGE[4] = '{
        longint'(saah_pkg::BAND_EDGE_0), longint'(saah_pkg::BAND_EDGE_1),
        longint'(saah_pkg::BAND_EDGE_2), longint'(saah_pkg::BAND_EDGE_3)
    };

    localparam logic signed [ANGLE_W-1:0] A_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ANGLE_W-1:0] A_MIN = 32'sh8000_0000;

    typedef struct {
        logic signed [ANGLE_W-1:0] target;
        logic signed [ANGLE_W-1:0] current;
        logic signed [ANGLE_W-1:0] rate;
        logic [AXIS_WIDTH-1:0]     axis;
    } tick_t;

    typedef struct {
        logic signed [LEVEL_W-1:0] level;
        logic                      done;
        logic [BAND_WIDTH-1:0]     band;
    } thrust_cmd_t;

    // dut signals, all inputs known from time zero
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic signed [ANGLE_W-1:0]     i_target_angle = '0;
    logic signed [ANGLE_W-1:0]     i_current_angle = '0;
    logic signed [ANGLE_W-1:0]     i_rot_rate = '0;
    logic [AXIS_WIDTH-1:0]         i_axis = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [LEVEL_W-1:0]     o_level;
    logic                          o_done_res;
    logic [BAND_WIDTH-1:0]         o_band;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]      i_cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]     i_cfg_data = '0;

    // shadow of the block's registers, starts at the reset values
    logic [DB_WIDTH-1:0]   sh_deadband = saah_pkg::DEADBAND_RST;
    logic [GAIN_WIDTH-1:0] sh_gain_x = saah_pkg::GAIN_RST;
    logic [GAIN_WIDTH-1:0] sh_gain_y = saah_pkg::GAIN_RST;
    logic [GAIN_WIDTH-1:0] sh_gain_z = saah_pkg::GAIN_RST;

    tick_t       pending_ticks[$];
    thrust_cmd_t expected_cmds[$];
    tick_t       on_bus;

    bit idle_on = 1'b1;
    int send_gap = 0;
    int recv_hold = 0;
    int quiet_cycles = 0;
    int fails = 0;
    int ticks_in = 0;
    int results_seen = 0;
    int settings = 1;
    int n_hold = 0;
    int n_damp = 0;
    int n_band = 0;

    single_axis_attitude_hold uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_target_angle (i_target_angle),
        .i_current_angle(i_current_angle),
        .i_rot_rate     (i_rot_rate),
        .i_axis         (i_axis),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_level        (o_level),
        .o_done_res     (o_done_res),
        .o_band         (o_band),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // idle or stall length for one transaction; none in burst phases
    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 9) : 0;
    endfunction

    // saturated magnitude of gain times rate error, q1.15
    function automatic logic [LEVEL_W-1:0] thrust_mag(logic [GAIN_WIDTH-1:0] g, longint m);
        logic [95:0] p;
        p = {64'd0, g} * {32'd0, 64'(m)};
        p = p >> PROD_SHIFT;
        if (p > 96'(LEVEL_FULL))
            return LEVEL_FULL;
        return p[LEVEL_W-1:0];
    endfunction

    function automatic logic signed [LEVEL_W-1:0] signed_thrust(logic [LEVEL_W-1:0] m, bit neg);
        return neg ? -m : m;
    endfunction

    // control law for one tick under the current register shadow
    function automatic thrust_cmd_t predict_hold(tick_t t);
        longint err, aerr, rate, arate, cmd, derr, aderr;
        logic [GAIN_WIDTH-1:0] g;
        int b;
        thrust_cmd_t r;
        r.level = '0;
        r.done = 1'b0;
        r.band = saah_pkg::BAND_HOLD;
        case (t.axis)
            saah_pkg::AXIS_PITCH: g = sh_gain_x;
            saah_pkg::AXIS_YAW:   g = sh_gain_y;
            saah_pkg::AXIS_ROLL:  g = sh_gain_z;
            default:              g = '0;
        endcase
        // error is exact, no wrap at the angle width
        err = longint'(t.target) - longint'(t.current);
        aerr = err < 0 ? -err : err;
        rate = longint'(t.rate);
        arate = rate < 0 ? -rate : rate;
        if (aerr < longint'({1'b0, sh_deadband})) begin
            if (arate < longint'(saah_pkg::RATE_NULL_Q))
                r.done = 1'b1;
            else
                r.level = signed_thrust(thrust_mag(g, arate), rate > 0);
        end else begin
            b = 0;
            while (b < 4 && aerr >= ERR_EDGE[b])
                b++;
            r.band = saah_pkg::BAND_FINE + BAND_WIDTH'(b);
            // zero error takes the positive commanded rate
            cmd = err < 0 ? -CMD_RATE[b] : CMD_RATE[b];
            derr = cmd - rate;
            aderr = derr < 0 ? -derr : derr;
            if (aderr > RATE_DB[b])
                r.level = signed_thrust(thrust_mag(g, aderr), derr < 0);
        end
        return r;
    endfunction

    function automatic tick_t mk_tick(logic signed [ANGLE_W-1:0] tgt,
                                      logic signed [ANGLE_W-1:0] cur,
                                      logic signed [ANGLE_W-1:0] rate,
                                      logic [AXIS_WIDTH-1:0] ax);
        tick_t t;
        t.target = tgt;
        t.current = cur;
        t.rate = rate;
        t.axis = ax;
        return t;
    endfunction

    // mostly plausible geometry around the deadband, the band edges and the
    // commanded rates; the rest raw noise so every input bit toggles
    function automatic tick_t random_tick();
        tick_t t;
        longint mag, err, rate;
        int k;
        t.axis = ($urandom_range(0, 15) == 0) ? 2'd3 : AXIS_WIDTH'($urandom_range(0, 2));
        if ($urandom_range(0, 7) == 0) begin
            t.target = $urandom;
            t.current = $urandom;
            t.rate = $urandom;
            return t;
        end
        case ($urandom_range(0, 5))
            0: mag = $urandom_range(0, sh_deadband > 100000 ? 100000 : 2 * sh_deadband + 8);
            1: begin
                k = $urandom_range(0, 3);
                mag = ERR_EDGE[k] + $urandom_range(0, 4) - 2;
            end
            2: mag = $urandom & 32'h07FF_FFFF;
            default: mag = $urandom_range(0, 3500000);
        endcase
        err = $urandom_range(0, 1) ? -mag : mag;
        t.target = $signed($urandom) >>> 1;
        t.current = t.target - ANGLE_W'(err);
        case ($urandom_range(0, 4))
            0: rate = longint'($urandom_range(0, 120)) - 60;
            1, 2: begin
                k = $urandom_range(0, 4);
                rate = CMD_RATE[k] + longint'($urandom_range(0, 6000)) - 3000;
                if ($urandom_range(0, 3) != 0 && err < 0)
                    rate = -rate;
            end
            3: rate = longint'($urandom_range(0, 2097152)) - 1048576;
            default: rate = longint'($signed($urandom));
        endcase
        t.rate = ANGLE_W'(rate);
        return t;
    endfunction

    // input side: one tick per transaction, random idle between them
    always @(posedge i_clk) begin : tick_driver
        tick_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                expected_cmds.push_back(predict_hold(on_bus));
                ticks_in++;
            end
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                nxt = pending_ticks.pop_front();
                on_bus <= nxt;
                i_target_angle <= nxt.target;
                i_current_angle <= nxt.current;
                i_rot_rate <= nxt.rate;
                i_axis <= nxt.axis;
                i_valid <= 1'b1;
                send_gap <= draw_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side: compare each transaction with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        thrust_cmd_t want;
        int hold;
        hold = recv_hold;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_cmds.size() == 0) begin
                $error("result transaction with no tick outstanding");
                fails++;
            end else begin
                want = expected_cmds.pop_front();
                if (want.done)
                    n_hold++;
                else if (want.band == saah_pkg::BAND_HOLD)
                    n_damp++;
                else
                    n_band++;
                if (o_level !== want.level) begin
                    $error("level: expected %0d, got %0d", want.level, o_level);
                    fails++;
                end
                if (o_done_res !== want.done) begin
                    $error("done_res: expected %0d, got %0d", want.done, o_done_res);
                    fails++;
                end
                if (o_band !== want.band) begin
                    $error("band: expected %0d, got %0d", want.band, o_band);
                    fails++;
                end
            end
            hold = draw_gap();
        end
        if (hold != 0) begin
            i_stall <= 1'b1;
            recv_hold <= hold - 1;
        end else begin
            i_stall <= 1'b0;
            recv_hold <= 0;
        end
    end

    // hang detection: any transaction on any channel resets the count
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("single_axis_attitude_hold_tb NOT OK");
            $finish;
        end
    end

    // one register write transaction, shadow follows on acceptance
    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            saah_pkg::REG_ANGLE_DEADBAND: sh_deadband = data[DB_WIDTH-1:0];
            saah_pkg::REG_GAIN_X:         sh_gain_x = data;
            saah_pkg::REG_GAIN_Y:         sh_gain_y = data;
            saah_pkg::REG_GAIN_Z:         sh_gain_z = data;
            default: ;
        endcase
    endtask

    task automatic load_setting(logic [DB_WIDTH-1:0] db, logic [GAIN_WIDTH-1:0] gx,
                                logic [GAIN_WIDTH-1:0] gy, logic [GAIN_WIDTH-1:0] gz);
        write_reg(saah_pkg::REG_ANGLE_DEADBAND, {1'b0, db});
        write_reg(saah_pkg::REG_GAIN_X, gx);
        write_reg(saah_pkg::REG_GAIN_Y, gy);
        write_reg(saah_pkg::REG_GAIN_Z, gz);
        settings++;
    endtask

    // block is idle once every tick is sent and every result is back;
    // sampled away from the rising edge so the driver and monitor have settled
    task automatic drain();
        while (pending_ticks.size() != 0 || i_valid || expected_cmds.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_random(int n);
        repeat (n) pending_ticks.push_back(random_tick());
    endtask

    function automatic logic [GAIN_WIDTH-1:0] random_gain();
        return ($urandom_range(0, 5) == 0) ? $urandom : $urandom >> $urandom_range(0, 24);
    endfunction

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: hold, damping both ways, band edges, rate deadband edges
        pending_ticks.push_back(mk_tick(1000, 1000, 0, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(0, 0, 28, saah_pkg::AXIS_YAW));
        pending_ticks.push_back(mk_tick(0, 0, -28, saah_pkg::AXIS_ROLL));
        pending_ticks.push_back(mk_tick(0, 0, 29, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(0, 0, -29, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(500, -500, A_MAX, saah_pkg::AXIS_YAW));
        pending_ticks.push_back(mk_tick(0, 0, A_MIN, saah_pkg::AXIS_ROLL));
        pending_ticks.push_back(mk_tick(2927, 0, 100, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(0, 2928, 0, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(43922, 0, 0, saah_pkg::AXIS_YAW));
        pending_ticks.push_back(mk_tick(43923, 0, 0, saah_pkg::AXIS_YAW));
        pending_ticks.push_back(mk_tick(0, 292818, 0, saah_pkg::AXIS_ROLL));
        pending_ticks.push_back(mk_tick(878453, 0, 0, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(2928177, 0, 0, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(A_MAX, A_MIN, 0, saah_pkg::AXIS_ROLL));
        pending_ticks.push_back(mk_tick(A_MIN, A_MAX, A_MAX, saah_pkg::AXIS_YAW));
        // fine and low bands: rate exactly on command, then at and just past the rate deadband
        pending_ticks.push_back(mk_tick(10000, 0, 2928, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(10000, 0, 2928 - 1464, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(10000, 0, 2928 - 1465, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(100000, 0, 73204 + 2928, saah_pkg::AXIS_YAW));
        pending_ticks.push_back(mk_tick(100000, 0, 73204 + 2929, saah_pkg::AXIS_YAW));
        // axis three has no gain register
        pending_ticks.push_back(mk_tick(0, 0, 5000, 2'd3));
        pending_ticks.push_back(mk_tick(5000000, 0, -1000, 2'd3));
        queue_random(100);
        drain();

        // zero deadband, gains at the extremes, no idling
        idle_on = 1'b0;
        load_setting('0, 32'hFFFF_FFFF, '0, 32'd1);
        pending_ticks.push_back(mk_tick(7, 7, 0, saah_pkg::AXIS_PITCH));
        pending_ticks.push_back(mk_tick(7, 7, -100000, saah_pkg::AXIS_YAW));
        pending_ticks.push_back(mk_tick(-5, -5, A_MAX, saah_pkg::AXIS_ROLL));
        pending_ticks.push_back(mk_tick(0, 0, 0, saah_pkg::AXIS_PITCH));
        queue_random(120);
        drain();

        // widest deadband: nearly everything counts as on target
        idle_on = 1'b1;
        load_setting(31'h7FFF_FFFF, random_gain(), random_gain(), random_gain());
        queue_random(100);
        drain();

        for (int p = 0; p < 4; p++) begin
            idle_on = p[0];
            load_setting(($urandom_range(0, 3) == 0) ? DB_WIDTH'($urandom)
                                                     : DB_WIDTH'($urandom_range(0, 60000)),
                         random_gain(), random_gain(), random_gain());
            queue_random(130);
            drain();
        end

        // every tick sent must have come back exactly once
        if (expected_cmds.size() != 0 || ticks_in != results_seen) begin
            $error("ticks sent %0d, results checked %0d", ticks_in, results_seen);
            fails++;
        end

        $display("%0d ticks sent, %0d results checked across %0d register settings",
                 ticks_in, results_seen, settings);
        $display("%0d on target, %0d damping, %0d banded results", n_hold, n_damp, n_band);
        if (fails == 0)
            $display("single_axis_attitude_hold_tb OK");
        else
            $display("single_axis_attitude_hold_tb NOT OK");
        $finish;
    end

endmodule

// ----- single_axis_attitude_hold.f -----
+incdir+hdl
hdl/saah_pkg.sv
hdl/saah_cfg.sv
hdl/saah_law.sv
hdl/saah_scale.sv
hdl/single_axis_attitude_hold.sv
hdl/saah_checker.sv
tb/sv/single_axis_attitude_hold_tb.sv
